### src/waek_pkg.sv
// ----------------------------------------------------------------------------
// waek_pkg
// types, constants and step functions shared by the wind-aware kernel
// ----------------------------------------------------------------------------
package waek_pkg;

  localparam int DW       = 17;  // position difference
  localparam int PW       = 34;  // second order products of differences
  localparam int QW       = 68;  // exact quadratic form, 32 fraction bits
  localparam int SQ_IN_W  = 40;  // q below 256 in q8.32
  localparam int ROOT_W   = 20;  // sqrt in q4.16
  localparam int REM_W    = 22;
  localparam int SQ_STG   = 10;  // two root bits per stage
  localparam int EXP_BITS = 20;

  typedef enum logic [2:0] {
    REG_WIND_COS    = 3'd0,
    REG_WIND_SIN    = 3'd1,
    REG_UP_INV_XX   = 3'd2,
    REG_UP_INV_XY   = 3'd3,
    REG_UP_INV_YY   = 3'd4,
    REG_DOWN_INV_XX = 3'd5,
    REG_DOWN_INV_XY = 3'd6,
    REG_DOWN_INV_YY = 3'd7
  } reg_idx_t;

  localparam logic [31:0] EXP_TAB [EXP_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic [SQ_IN_W-1:0] qsh;
    logic               big;
    logic               up;
  } sq_t;

  typedef struct packed {
    logic [31:0]        acc;
    logic               one;
    logic [ROOT_W-1:0]  s;
    logic               big;
    logic               up;
  } ex_t;

  // two restoring square root steps
  function automatic sq_t sq_step(sq_t a);
    sq_t              r;
    logic [REM_W+1:0] remw;
    logic [REM_W+1:0] trial;
    r = a;
    for (int k = 0; k < 2; k++) begin
      remw  = {r.rem, r.qsh[SQ_IN_W-1 -: 2]};
      r.qsh = {r.qsh[SQ_IN_W-3:0], 2'b00};
      trial = (REM_W+2)'({r.root, 2'b01});
      if (remw >= trial) begin
        remw   = remw - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
      r.rem = remw[REM_W-1:0];
    end
    return r;
  endfunction

  // one exp factor for root bit idx
  function automatic ex_t ex_step(ex_t a, logic [4:0] idx);
    ex_t         r;
    logic [63:0] prod;
    r    = a;
    prod = 64'(a.acc) * 64'(EXP_TAB[idx]) + 64'h8000_0000;
    if (a.s[idx]) begin
      if (a.one) begin
        r.acc = EXP_TAB[idx];
        r.one = 1'b0;
      end else begin
        r.acc = prod[63:32];
      end
    end
    return r;
  endfunction

endpackage

### src/wind_aware_exponential_kernel.sv
// ----------------------------------------------------------------------------
// wind_aware_exponential_kernel
// exp(-sqrt(d' M d)) with M picked by the side of the wind that d points to
// ----------------------------------------------------------------------------
// channel | dir | word
// in_     | in  | first_x, first_y, second_x, second_y
// out_    | out | kernel_value, used_upwind in tuser
// cfg_    | in  | register index and data, always ready
//
// one word per cycle while the skid register is empty; 4 arithmetic stages, 10
// square root stages, 20 exp multiply stages, then the output register.
// rst_n clears valid bits and loads register defaults.
// a skid register behind the output register stops the pipeline while it holds
// a result that met a stalled output; in_tready comes straight from a register.
module wind_aware_exponential_kernel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_x, first_y, second_x, second_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // kernel_value
  output logic [0:0]  out_tuser,  // used_upwind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import waek_pkg::*;

  logic signed [15:0] wc_r, ws_r;
  logic signed [31:0] uxx_r, uxy_r, uyy_r, dxx_r, dxy_r, dyy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= 16'sd16384;
      ws_r  <= '0;
      uxx_r <= 32'sd65536;
      uxy_r <= '0;
      uyy_r <= 32'sd65536;
      dxx_r <= 32'sd65536;
      dxy_r <= '0;
      dyy_r <= 32'sd65536;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_WIND_COS:    wc_r  <= cfg_data[15:0];
        REG_WIND_SIN:    ws_r  <= cfg_data[15:0];
        REG_UP_INV_XX:   uxx_r <= cfg_data;
        REG_UP_INV_XY:   uxy_r <= cfg_data;
        REG_UP_INV_YY:   uyy_r <= cfg_data;
        REG_DOWN_INV_XX: dxx_r <= cfg_data;
        REG_DOWN_INV_XY: dxy_r <= cfg_data;
        REG_DOWN_INV_YY: dyy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic ov_r, sv_r;
  logic [3:0] fv_r;
  logic [SQ_STG-1:0] sqv_r;
  logic [EXP_BITS-1:0] exv_r;

  assign en        = !sv_r;
  assign in_tready = en;

  // stage 1: differences
  logic signed [DW-1:0] dx_r, dy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'($signed(in_tdata[15:0])) - DW'($signed(in_tdata[47:32]));
      dy_r <= DW'($signed(in_tdata[31:16])) - DW'($signed(in_tdata[63:48]));
    end
  end

  // stage 2: wind side and products of differences
  logic signed [PW-1:0] dot;
  logic signed [PW-1:0] pxx_r, pxy_r, pyy_r;
  logic                 up2_r;
  assign dot = PW'(dx_r * wc_r) + PW'(dy_r * ws_r);
  always_ff @(posedge clk) begin
    if (en) begin
      up2_r <= dot[PW-1] || (dot == '0);
      pxx_r <= PW'(dx_r * dx_r);
      pxy_r <= PW'(dx_r * dy_r);
      pyy_r <= PW'(dy_r * dy_r);
    end
  end

  // stage 3: matrix times products, split in 17 bit halves
  logic signed [31:0] mxx, mxy, myy;
  logic signed [49:0] lxx_r, lxy_r, lyy_r;
  logic signed [48:0] hxx_r, hxy_r, hyy_r;
  logic               up3_r;
  assign mxx = up2_r ? uxx_r : dxx_r;
  assign mxy = up2_r ? uxy_r : dxy_r;
  assign myy = up2_r ? uyy_r : dyy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      up3_r <= up2_r;
      lxx_r <= mxx * $signed({1'b0, pxx_r[16:0]});
      lxy_r <= mxy * $signed({1'b0, pxy_r[16:0]});
      lyy_r <= myy * $signed({1'b0, pyy_r[16:0]});
      hxx_r <= mxx * $signed(pxx_r[PW-1:17]);
      hxy_r <= mxy * $signed(pxy_r[PW-1:17]);
      hyy_r <= myy * $signed(pyy_r[PW-1:17]);
    end
  end

  // stage 4: quadratic form
  logic signed [QW-1:0] txx, txy, tyy, q_r;
  logic                 up4_r;
  assign txx = (QW'(hxx_r) <<< 17) + QW'(lxx_r);
  assign txy = (QW'(hxy_r) <<< 17) + QW'(lxy_r);
  assign tyy = (QW'(hyy_r) <<< 17) + QW'(lyy_r);
  always_ff @(posedge clk) begin
    if (en) begin
      up4_r <= up3_r;
      q_r   <= txx + (txy <<< 1) + tyy;
    end
  end

  // clamp and square root stages
  sq_t sq_in;
  sq_t sq_r [SQ_STG];
  always_comb begin
    sq_in      = '0;
    sq_in.up   = up4_r;
    sq_in.big  = !q_r[QW-1] && (q_r[QW-2:SQ_IN_W] != '0);
    sq_in.qsh  = q_r[QW-1] ? '0 : q_r[SQ_IN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq_step(sq_in);
      for (int k = 1; k < SQ_STG; k++) begin
        sq_r[k] <= sq_step(sq_r[k-1]);
      end
    end
  end

  // exp product stages, root bit 0 first
  ex_t ex_in;
  ex_t ex_r [EXP_BITS];
  always_comb begin
    ex_in     = '0;
    ex_in.one = 1'b1;
    ex_in.s   = sq_r[SQ_STG-1].root;
    ex_in.big = sq_r[SQ_STG-1].big;
    ex_in.up  = sq_r[SQ_STG-1].up;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r[0] <= ex_step(ex_in, 5'd0);
      for (int i = 1; i < EXP_BITS; i++) begin
        ex_r[i] <= ex_step(ex_r[i-1], 5'(i));
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r  <= '0;
      sqv_r <= '0;
      exv_r <= '0;
    end else if (en) begin
      fv_r  <= {fv_r[2:0], in_tvalid};
      sqv_r <= {sqv_r[SQ_STG-2:0], fv_r[3]};
      exv_r <= {exv_r[EXP_BITS-2:0], sqv_r[SQ_STG-1]};
    end
  end

  // rounding and saturation
  ex_t         ex_last;
  logic [32:0] rsum;
  logic [15:0] kv;
  assign ex_last = ex_r[EXP_BITS-1];
  assign rsum    = {1'b0, ex_last.acc} + 33'd32768;
  always_comb begin
    if (ex_last.big) begin
      kv = '0;
    end else if (ex_last.one || rsum[32]) begin
      kv = 16'hffff;
    end else begin
      kv = rsum[31:16];
    end
  end

  // output register and skid
  logic [15:0] okv_r, skv_r;
  logic        oup_r, sup_r;
  logic        pop, push;
  assign pop  = ov_r && out_tready;
  assign push = exv_r[EXP_BITS-1] && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (pop) begin
        sv_r <= 1'b0;
      end
    end else if (push) begin
      if (!ov_r || pop) begin
        ov_r <= 1'b1;
      end else begin
        sv_r <= 1'b1;
      end
    end else if (pop) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (pop) begin
        okv_r <= skv_r;
        oup_r <= sup_r;
      end
    end else if (push) begin
      if (!ov_r || pop) begin
        okv_r <= kv;
        oup_r <= ex_last.up;
      end else begin
        skv_r <= kv;
        sup_r <= ex_last.up;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = okv_r;
  assign out_tuser  = oup_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r) else $error("skid full while output empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r && exv_r[EXP_BITS-1] |=> exv_r[EXP_BITS-1])
    else $error("pipeline tail dropped during stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r && out_tready |=> !sv_r && ov_r) else $error("skid did not drain");
`endif

endmodule
